// ===== design/tlip_pkg.sv =====
// Package for the terminated line integer parser.
// Holds command and phase codes, character constants, shared types and helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tlip_pkg;

  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_TERM  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_WS     = 3'd1;
  localparam logic [2:0] PH_SIGN   = 3'd2;
  localparam logic [2:0] PH_ZERO   = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;
  localparam logic [2:0] PH_HEXPFX = 3'd5;
  localparam logic [2:0] PH_HEXDIG = 3'd6;

  localparam int unsigned FORM_DEC = 0;
  localparam int unsigned FORM_HEX = 1;
  localparam int unsigned FORM_BIN = 2;

  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_HEX = 2'd1;
  localparam logic [1:0] RADIX_BIN = 2'd2;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LC_B  = 8'h62;
  localparam logic [7:0] CH_LC_X  = 8'h78;
  localparam logic [7:0] CH_UC_X  = 8'h58;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;

  localparam logic [7:0] TERM_RESET = 8'h0A;

  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = 2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_code;
  } cmd_t;

  typedef struct packed {
    logic        saturated;
    logic [1:0]  radix_used;
    logic [31:0] int_value;
    logic        int_valid;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Digit value of a hex character, or 16 when it is not a hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if ((c >= CH_ZERO) && (c <= CH_NINE)) v = 5'(c - CH_ZERO);
    else if ((c >= CH_LC_A) && (c <= CH_LC_F)) v = 5'(c - CH_LC_A + 8'd10);
    else if ((c >= CH_UC_A) && (c <= CH_UC_F)) v = 5'(c - CH_UC_A + 8'd10);
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== design/tlip_front.sv =====
// Front end of the parser: accepts input items and classifies them.
// Holds the terminator register. Depends on tlip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlip_front (
  input  wire              clk,
  input  wire              rst,
  input  wire              cfg_wr_en,
  input  wire  [7:0]       cfg_wr_data,
  input  wire              s_tvalid,
  output logic             s_tready,
  input  wire  [7:0]       s_tdata,   // char_code
  input  wire              s_tuser,   // opcode
  input  wire              q_full,
  output logic             push,
  output tlip_pkg::cmd_t   push_cmd
);
  import tlip_pkg::*;

  logic [7:0] terminator;
  logic       keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      terminator <= TERM_RESET;
    end else if (cfg_wr_en) begin
      terminator <= cfg_wr_data;
    end
  end

  always_comb begin
    push_cmd.char_code = s_tdata;
    keep = 1'b1;
    if (s_tuser) begin
      push_cmd.kind = KIND_CLEAR;
    end else if (s_tdata == terminator) begin
      push_cmd.kind = KIND_TERM;
    end else begin
      push_cmd.kind = KIND_CHAR;
      keep = !((s_tdata == CH_LF) || (s_tdata == CH_CR));
    end
  end

  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready && keep;

endmodule

`default_nettype wire

// ===== design/tlip_queue.sv =====
// Short command queue between the front end and the parser core.
// Depends on tlip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlip_queue (
  input  wire             clk,
  input  wire             rst,
  input  wire             push,
  input  tlip_pkg::cmd_t  push_cmd,
  output logic            full,
  input  wire             pop,
  output logic            q_valid,
  output tlip_pkg::cmd_t  q_cmd
);
  import tlip_pkg::*;

  cmd_t            mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  assign full    = (count == (Q_AW+1)'(Q_DEPTH));
  assign q_valid = (count != '0);
  assign q_cmd   = mem[rd_ptr];

endmodule

`default_nettype wire

// ===== design/tlip_back.sv =====
// Parser core: runs the line state machine and the three accumulators.
// Holds the result register. Depends on tlip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlip_back #(
  parameter int LINE_CAPACITY = 64
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               q_valid,
  input  tlip_pkg::cmd_t    q_cmd,
  output logic              pop,
  output logic              m_tvalid,
  input  wire               m_tready,
  output tlip_pkg::result_t res
);
  import tlip_pkg::*;

  localparam int LEN_W = $clog2(LINE_CAPACITY + 1);

  logic [LEN_W-1:0] line_length, line_length_next;
  logic [2:0]       phase, phase_next;
  logic             neg, neg_next;
  logic [31:0]      dec_acc, dec_acc_next;
  logic [31:0]      hex_acc, hex_acc_next;
  logic [31:0]      bin_acc, bin_acc_next;
  logic [2:0]       form_ok, form_ok_next;
  logic [2:0]       sat_flags, sat_flags_next;
  result_t          fin;

  always_comb begin
    logic [LEN_W-1:0] len;
    logic [2:0]  ph, ok, sf;
    logic        ng, done, first_dig, sp, sg, is_dec;
    logic [31:0] da, ha, ba, mag;
    logic [7:0]  c;
    logic [4:0]  d;
    logic [35:0] dsum, hsum;
    logic [32:0] bsum;
    logic [31:0] dcap, hcap, bcap;
    logic        dovf, hovf, bovf, satf, fvalid;
    logic [1:0]  radix;

    c  = q_cmd.char_code;
    d  = hex_val(c);
    sp = is_space(c);
    sg = (c == CH_PLUS) || (c == CH_MINUS);
    is_dec = (c >= CH_ZERO) && (c <= CH_NINE);

    len = line_length; ph = phase; ng = neg; da = dec_acc; ha = hex_acc; ba = bin_acc;
    ok = form_ok; sf = sat_flags;
    if (line_length >= LEN_W'(LINE_CAPACITY)) begin
      len = '0; ph = PH_START; ng = 1'b0; da = '0; ha = '0; ba = '0;
      ok = 3'b111; sf = 3'b000;
    end

    dsum = ({4'b0, da} << 3) + ({4'b0, da} << 1) + {32'b0, d[3:0]};
    hsum = ({4'b0, ha} << 4) + {32'b0, d[3:0]};
    bsum = ({1'b0, ba} << 1) + {32'b0, d[0]};
    dovf = dsum > {4'b0, MAG_LIMIT};
    hovf = hsum > {4'b0, MAG_LIMIT};
    bovf = bsum > {1'b0, MAG_LIMIT};
    dcap = dovf ? MAG_LIMIT : dsum[31:0];
    hcap = hovf ? MAG_LIMIT : hsum[31:0];
    bcap = bovf ? MAG_LIMIT : bsum[31:0];

    fvalid = 1'b0; radix = RADIX_DEC; mag = '0; satf = 1'b0;
    if (len == '0) begin
      fvalid = 1'b1;
    end else if (ok[FORM_DEC] && ((ph == PH_ZERO) || (ph == PH_DIGITS))) begin
      fvalid = 1'b1; radix = RADIX_DEC; mag = da; satf = sf[FORM_DEC];
    end else if (ok[FORM_HEX] && (ph == PH_HEXDIG)) begin
      fvalid = 1'b1; radix = RADIX_HEX; mag = ha; satf = sf[FORM_HEX];
    end else if (ok[FORM_BIN] && (len >= LEN_W'(2)) && (ph == PH_DIGITS)) begin
      fvalid = 1'b1; radix = RADIX_BIN; mag = ba; satf = sf[FORM_BIN];
    end
    fin.int_valid  = fvalid;
    fin.radix_used = radix;
    fin.int_value  = '0;
    fin.saturated  = 1'b0;
    if (fvalid && (len != '0)) begin
      if (ng) begin
        if (satf) begin
          fin.int_value = MAG_LIMIT; fin.saturated = 1'b1;
        end else begin
          fin.int_value = 32'd0 - mag;
        end
      end else if (satf || (mag > POS_MAX)) begin
        fin.int_value = POS_MAX; fin.saturated = 1'b1;
      end else begin
        fin.int_value = mag;
      end
    end

    done = 1'b0;
    if (len == '0) begin
      if (c != CH_ZERO) ok[FORM_BIN] = 1'b0;
    end else if (len == LEN_W'(1)) begin
      if (ok[FORM_BIN] && (c == CH_LC_B)) begin
        ok = 3'b100; ph = PH_WS; done = 1'b1;
      end else begin
        ok[FORM_BIN] = 1'b0;
      end
    end

    if (!done && ok[FORM_BIN] && (len >= LEN_W'(2))) begin
      done = 1'b1;
      if (sp && (ph == PH_WS)) begin
        ph = PH_WS;
      end else if (sg && (ph == PH_WS)) begin
        ph = PH_SIGN; ng = (c == CH_MINUS);
      end else if ((d < 5'd2) &&
                   ((ph == PH_WS) || (ph == PH_SIGN) || (ph == PH_DIGITS))) begin
        ph = PH_DIGITS; ba = bcap; sf[FORM_BIN] = sf[FORM_BIN] | bovf;
      end else begin
        ok = 3'b000;
      end
    end

    if (!done && (ok[FORM_HEX:FORM_DEC] == 2'b00)) done = 1'b1;

    first_dig = (ph == PH_SIGN) || (((ph == PH_START) || (ph == PH_WS)) && !sp && !sg);
    if (!done) begin
      if (first_dig) begin
        if (c == CH_ZERO) begin
          ph = PH_ZERO; da = '0;
        end else if ((c >= CH_ONE) && (c <= CH_NINE)) begin
          ph = PH_DIGITS; ok[FORM_HEX] = 1'b0; da = {28'b0, d[3:0]};
        end else begin
          ok[FORM_HEX:FORM_DEC] = 2'b00;
        end
      end else begin
        unique case (ph) inside
          PH_START, PH_WS: begin
            if (sp) begin
              ph = PH_WS;
            end else begin
              ph = PH_SIGN; ng = (c == CH_MINUS);
            end
          end
          PH_ZERO: begin
            if ((c == CH_LC_X) || (c == CH_UC_X)) begin
              ph = PH_HEXPFX; ok[FORM_DEC] = 1'b0;
            end else if (is_dec) begin
              ph = PH_DIGITS; ok[FORM_HEX] = 1'b0; da = dcap;
              sf[FORM_DEC] = sf[FORM_DEC] | dovf;
            end else begin
              ok[FORM_HEX:FORM_DEC] = 2'b00;
            end
          end
          PH_DIGITS: begin
            if (is_dec) begin
              da = dcap; sf[FORM_DEC] = sf[FORM_DEC] | dovf;
            end else begin
              ok[FORM_HEX:FORM_DEC] = 2'b00;
            end
          end
          PH_HEXPFX, PH_HEXDIG: begin
            if (d < 5'd16) begin
              ph = PH_HEXDIG; ha = hcap; sf[FORM_HEX] = sf[FORM_HEX] | hovf;
            end else begin
              ok[FORM_HEX:FORM_DEC] = 2'b00;
            end
          end
          default: begin
            ok[FORM_HEX:FORM_DEC] = 2'b00;
          end
        endcase
      end
    end

    line_length_next = len + 1'b1;
    phase_next = ph; neg_next = ng; dec_acc_next = da; hex_acc_next = ha;
    bin_acc_next = ba; form_ok_next = ok; sat_flags_next = sf;
  end

  assign pop = q_valid && ((q_cmd.kind != KIND_TERM) || !m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= '0; phase <= PH_START; neg <= 1'b0;
      dec_acc <= '0; hex_acc <= '0; bin_acc <= '0;
      form_ok <= 3'b111; sat_flags <= 3'b000;
    end else if (pop) begin
      if (q_cmd.kind == KIND_CHAR) begin
        line_length <= line_length_next; phase <= phase_next; neg <= neg_next;
        dec_acc <= dec_acc_next; hex_acc <= hex_acc_next; bin_acc <= bin_acc_next;
        form_ok <= form_ok_next; sat_flags <= sat_flags_next;
      end else begin
        line_length <= '0; phase <= PH_START; neg <= 1'b0;
        dec_acc <= '0; hex_acc <= '0; bin_acc <= '0;
        form_ok <= 3'b111; sat_flags <= 3'b000;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop && (q_cmd.kind == KIND_TERM)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (q_cmd.kind == KIND_TERM)) begin
      res <= fin;
    end
  end

`ifndef ASSERT_OFF
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !res.int_valid) |->
      (res.int_value == 32'd0) && (res.radix_used == RADIX_DEC) && !res.saturated)
    else $error("invalid line result carries nonzero fields");
  a_sat_limits: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.saturated) |->
      ((res.int_value == POS_MAX) || (res.int_value == MAG_LIMIT)))
    else $error("saturated result is not a 32-bit limit");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !(pop && (q_cmd.kind == KIND_TERM)))
    else $error("result register overwritten while stalled");
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    line_length <= LEN_W'(LINE_CAPACITY))
    else $error("line length beyond capacity");
`endif

endmodule

`default_nettype wire

// ===== design/terminated_line_integer_parser.sv =====
// A terminator is queued; its pop by the core sets m_tvalid and loads the result register,
// after any queued items or stalled result ahead of it. Throughput: one item per cycle while
// the queue is not full; a four-entry command queue separates intake from parsing, and the
// parser core retires one character per cycle with constant shift-add accumulators.
// Reset (synchronous, rst high): terminator returns to LF, the line state is cleared,
// the queue empties and no result is pending.
`timescale 1ns / 1ps
`default_nettype none

module terminated_line_integer_parser #(
  parameter int LINE_CAPACITY = 64
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_wr_en,
  input  wire  [7:0]  cfg_wr_data,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // char_code
  input  wire         s_tuser,   // opcode
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [39:0] m_tdata,   // int_valid, int_value[31:0], saturated, zero fill
  output logic [1:0]  m_tuser    // radix_used
);
  import tlip_pkg::*;

  logic    push, full, pop, q_valid;
  cmd_t    push_cmd, q_cmd;
  result_t res;

  tlip_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .q_full      (full),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  tlip_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  tlip_back #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .res      (res)
  );

  assign m_tdata = {6'b0, res.saturated, res.int_value, res.int_valid};
  assign m_tuser = res.radix_used;

endmodule

`default_nettype wire
